[hw/rtl/assert_macros.svh]
// Assertion helpers used by tagged_record_store.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while in reset.
`define CHK_IMPLY(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while in reset.
`define CHK_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hw/rtl/trs_pkg.sv]
package trs_pkg;

    localparam logic [1:0] K_START = 2'd0;
    localparam logic [1:0] K_WORD  = 2'd1;
    localparam logic [1:0] K_LOAD  = 2'd2;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_RESERVED  = 3'd1;
    localparam logic [2:0] ST_NO_ROOM   = 3'd2;
    localparam logic [2:0] ST_NOT_FOUND = 3'd3;
    localparam logic [2:0] ST_LENGTH    = 3'd4;
    localparam logic [2:0] ST_CRC       = 3'd5;

    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] tag;
        logic [7:0]  length;
        logic [31:0] data;
        logic        last;
    } cmd_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [31:0] payload_word;
        logic [2:0]  valid_bytes;
        logic        final_res;
    } res_t;

endpackage

[hw/rtl/trs_fifo.sv]
module trs_fifo #(
    parameter int W     = 8,
    parameter int DEPTH = 4
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         wr_en,
    input  logic [W-1:0] wr_data,
    output logic         full,
    input  logic         rd_en,
    output logic [W-1:0] rd_data,
    output logic         empty
);
    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [W-1:0] slots [DEPTH];
    logic [PW:0]  wr_ptr_reg;
    logic [PW:0]  wr_ptr_next;
    logic [PW:0]  rd_ptr_reg;
    logic [PW:0]  rd_ptr_next;
    logic [PW:0]  count;

    assign count   = wr_ptr_reg - rd_ptr_reg;
    assign full    = (count == (PW + 1)'(DEPTH));
    assign empty   = (count == '0);
    assign rd_data = slots[rd_ptr_reg[PW-1:0]];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (wr_en && !full)
        begin
            wr_ptr_next = (wr_ptr_reg[PW-1:0] == PW'(DEPTH - 1)) ?
                          {~wr_ptr_reg[PW], {PW{1'b0}}} : wr_ptr_reg + 1'b1;
        end
        if (rd_en && !empty)
        begin
            rd_ptr_next = (rd_ptr_reg[PW-1:0] == PW'(DEPTH - 1)) ?
                          {~rd_ptr_reg[PW], {PW{1'b0}}} : rd_ptr_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en && !full)
        begin
            slots[wr_ptr_reg[PW-1:0]] <= wr_data;
        end
    end
endmodule

[hw/rtl/trs_front.sv]
module trs_front (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    output logic          full,
    input  logic          action,
    input  logic [15:0]   tag,
    input  logic [7:0]    length,
    input  logic [31:0]   data_word,
    input  logic          last,
    input  logic          hold,
    input  logic          cmd_full,
    output logic          cmd_push,
    output trs_pkg::cmd_t cmd
);
    import trs_pkg::*;

    logic in_save_reg;
    logic in_save_next;

    // A save word is the start of a save unless an earlier word left it open.
    assign full     = cmd_full | hold;
    assign cmd_push = push & ~full;

    always_comb
    begin
        cmd.kind   = action ? K_LOAD : (in_save_reg ? K_WORD : K_START);
        cmd.tag    = tag;
        cmd.length = length;
        cmd.data   = data_word;
        cmd.last   = last;
        in_save_next = in_save_reg;
        if (cmd_push && !action)
        begin
            in_save_next = ~last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_save_reg <= 1'b0;
        end
        else
        begin
            in_save_reg <= in_save_next;
        end
    end
endmodule

[hw/rtl/trs_engine.sv]
module trs_engine #(
    parameter int REGION_BYTES     = 4096,
    parameter int MAX_RECORD_BYTES = 252
) (
    input  logic          clk,
    input  logic          rst_n,
    input  trs_pkg::cmd_t cmd,
    input  logic          cmd_empty,
    output logic          cmd_pop,
    output trs_pkg::res_t res,
    output logic          res_push,
    input  logic          res_full,
    output logic          clearing
);
    import trs_pkg::*;

    localparam int RW     = REGION_BYTES / 4;
    localparam int AW     = $clog2(RW);
    localparam int SW     = 16;
    localparam logic [SW-1:0] RW_S  = SW'(RW);
    localparam logic [15:0]   MAX_L = 16'(MAX_RECORD_BYTES);

    localparam logic [31:0] MAGIC    = 32'h4B524B53;
    localparam logic [31:0] VERSION  = 32'h00000001;
    localparam logic [31:0] CRC_POLY = 32'hEDB88320;
    localparam logic [31:0] CRC_INIT = 32'hFFFFFFFF;
    localparam logic [15:0] ERASED   = 16'hFFFF;

    localparam logic [4:0] S_CLR      = 5'd0;
    localparam logic [4:0] S_IDLE     = 5'd1;
    localparam logic [4:0] S_HDR0     = 5'd2;
    localparam logic [4:0] S_HDR1     = 5'd3;
    localparam logic [4:0] S_HDR2     = 5'd4;
    localparam logic [4:0] S_SCAN_RD  = 5'd5;
    localparam logic [4:0] S_SCAN_CHK = 5'd6;
    localparam logic [4:0] S_SCAN_END = 5'd7;
    localparam logic [4:0] S_FIT      = 5'd8;
    localparam logic [4:0] S_CMP_RD   = 5'd9;
    localparam logic [4:0] S_CMP_CHK  = 5'd10;
    localparam logic [4:0] S_CP_RD    = 5'd11;
    localparam logic [4:0] S_CP_WR    = 5'd12;
    localparam logic [4:0] S_FILL     = 5'd13;
    localparam logic [4:0] S_HDRW0    = 5'd14;
    localparam logic [4:0] S_HDRW1    = 5'd15;
    localparam logic [4:0] S_WORD     = 5'd16;
    localparam logic [4:0] S_BYTE     = 5'd17;
    localparam logic [4:0] S_WEND     = 5'd18;
    localparam logic [4:0] S_TAGW     = 5'd19;
    localparam logic [4:0] S_EMIT     = 5'd20;
    localparam logic [4:0] S_LHDR     = 5'd21;
    localparam logic [4:0] S_LCHK     = 5'd22;
    localparam logic [4:0] S_LCRCW    = 5'd23;
    localparam logic [4:0] S_LC_RD    = 5'd24;
    localparam logic [4:0] S_LC_BYTES = 5'd25;
    localparam logic [4:0] S_LC_CMP   = 5'd26;
    localparam logic [4:0] S_LW_RD    = 5'd27;
    localparam logic [4:0] S_LW_EMIT  = 5'd28;

    function automatic logic [31:0] crc_byte(input logic [31:0] crc_in, input logic [7:0] b);
        logic [31:0] c;
        c = crc_in ^ {24'h0, b};
        for (int k = 0; k < 8; k++)
        begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

    function automatic logic [SW-1:0] rec_words(input logic [15:0] len);
        logic [16:0] padded;
        padded = {1'b0, len} + 17'd3;
        return SW'(2) + SW'(padded >> 2);
    endfunction

    logic [31:0] mem [RW];
    logic [31:0] rdata_reg;
    logic          re;
    logic [AW-1:0] raddr;
    logic          we;
    logic [AW-1:0] waddr;
    logic [31:0]   wdata;

    logic [4:0]    state_reg,   state_next;
    logic [SW-1:0] pos_reg,     pos_next;
    logic [1:0]    verdict_reg, verdict_next;
    logic [7:0]    taken_reg,   taken_next;
    logic [31:0]   crc_reg,     crc_next;
    logic [SW-1:0] wpos_reg,    wpos_next;
    logic [15:0]   stag_reg,    stag_next;
    logic [7:0]    slen_reg,    slen_next;

    logic [15:0]   ltag_reg,    ltag_next;
    logic [7:0]    llen_reg,    llen_next;
    logic [31:0]   data_reg,    data_next;
    logic          last_reg,    last_next;
    logic          load_reg,    load_next;
    logic          hdr_ok_reg,  hdr_ok_next;
    logic          valid_reg,   valid_next;
    logic [SW-1:0] kept_reg,    kept_next;
    logic [SW-1:0] end_reg,     end_next;
    logic [SW-1:0] src_reg,     src_next;
    logic [SW-1:0] dst_reg,     dst_next;
    logic [SW-1:0] sz_reg,      sz_next;
    logic [SW-1:0] cnt_reg,     cnt_next;
    logic          hit_reg,     hit_next;
    logic [SW-1:0] hitpos_reg,  hitpos_next;
    logic [8:0]    idx_reg,     idx_next;
    logic [2:0]    bcnt_reg,    bcnt_next;
    logic [7:0]    wbase_reg,   wbase_next;
    logic [31:0]   wacc_reg,    wacc_next;
    logic [31:0]   lcrc_reg,    lcrc_next;
    logic [31:0]   crcst_reg,   crcst_next;
    res_t          res_reg,     res_next;

    logic [SW-1:0] rec_sz;
    logic [SW-1:0] next_pos;
    logic [7:0]    cur_byte;
    logic [7:0]    rd_byte;
    logic [8:0]    remain;
    logic [2:0]    vb;
    logic [31:0]   pw;

    assign clearing = (state_reg == S_CLR);
    assign rec_sz   = rec_words(rdata_reg[31:16]);
    assign next_pos = pos_reg + rec_sz;
    assign cur_byte = data_reg[{bcnt_reg[1:0], 3'b000} +: 8];
    assign rd_byte  = rdata_reg[{bcnt_reg[1:0], 3'b000} +: 8];
    assign remain   = {1'b0, llen_reg} - idx_reg;
    assign vb       = (remain > 9'd4) ? 3'd4 : remain[2:0];

    always_comb
    begin
        for (int j = 0; j < 4; j++)
        begin
            pw[8*j +: 8] = (3'(j) < vb) ? rdata_reg[8*j +: 8] : 8'h00;
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        pos_next     = pos_reg;
        verdict_next = verdict_reg;
        taken_next   = taken_reg;
        crc_next     = crc_reg;
        wpos_next    = wpos_reg;
        stag_next    = stag_reg;
        slen_next    = slen_reg;
        ltag_next    = ltag_reg;
        llen_next    = llen_reg;
        data_next    = data_reg;
        last_next    = last_reg;
        load_next    = load_reg;
        hdr_ok_next  = hdr_ok_reg;
        valid_next   = valid_reg;
        kept_next    = kept_reg;
        end_next     = end_reg;
        src_next     = src_reg;
        dst_next     = dst_reg;
        sz_next      = sz_reg;
        cnt_next     = cnt_reg;
        hit_next     = hit_reg;
        hitpos_next  = hitpos_reg;
        idx_next     = idx_reg;
        bcnt_next    = bcnt_reg;
        wbase_next   = wbase_reg;
        wacc_next    = wacc_reg;
        lcrc_next    = lcrc_reg;
        crcst_next   = crcst_reg;
        res_next     = res_reg;
        re       = 1'b0;
        raddr    = '0;
        we       = 1'b0;
        waddr    = '0;
        wdata    = '0;
        cmd_pop  = 1'b0;
        res_push = 1'b0;
        res      = res_reg;

        case (state_reg)
            S_CLR:
            begin
                we       = 1'b1;
                waddr    = pos_reg[AW-1:0];
                wdata    = '1;
                pos_next = pos_reg + 1'b1;
                if (pos_reg == RW_S - 1'b1)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (!cmd_empty)
                begin
                    cmd_pop   = 1'b1;
                    data_next = cmd.data;
                    last_next = cmd.last;
                    case (cmd.kind)
                        K_START:
                        begin
                            stag_next  = cmd.tag;
                            slen_next  = cmd.length;
                            taken_next = '0;
                            crc_next   = CRC_INIT;
                            load_next  = 1'b0;
                            if (cmd.tag == ERASED)
                            begin
                                verdict_next = ST_RESERVED[1:0];
                                state_next   = S_WORD;
                            end
                            else if ({8'h0, cmd.length} > MAX_L)
                            begin
                                verdict_next = ST_NO_ROOM[1:0];
                                state_next   = S_WORD;
                            end
                            else
                            begin
                                state_next = S_HDR0;
                            end
                        end
                        K_LOAD:
                        begin
                            ltag_next  = cmd.tag;
                            llen_next  = cmd.length;
                            load_next  = 1'b1;
                            state_next = S_HDR0;
                        end
                        default:
                        begin
                            state_next = S_WORD;
                        end
                    endcase
                end
            end
            S_HDR0:
            begin
                re         = 1'b1;
                raddr      = AW'(0);
                state_next = S_HDR1;
            end
            S_HDR1:
            begin
                hdr_ok_next = (rdata_reg == MAGIC);
                re          = 1'b1;
                raddr       = AW'(1);
                state_next  = S_HDR2;
            end
            S_HDR2:
            begin
                valid_next = hdr_ok_reg && (rdata_reg[15:0] == VERSION[15:0]);
                pos_next   = SW'(2);
                kept_next  = '0;
                hit_next   = 1'b0;
                end_next   = SW'(2);
                if (hdr_ok_reg && (rdata_reg[15:0] == VERSION[15:0]))
                begin
                    state_next = S_SCAN_RD;
                end
                else if (load_reg)
                begin
                    res_next   = '{ST_NOT_FOUND, 32'h0, 3'd0, 1'b1};
                    state_next = S_EMIT;
                end
                else
                begin
                    state_next = S_FIT;
                end
            end
            S_SCAN_RD:
            begin
                if (pos_reg + SW'(2) > RW_S)
                begin
                    state_next = S_SCAN_END;
                end
                else
                begin
                    re         = 1'b1;
                    raddr      = pos_reg[AW-1:0];
                    state_next = S_SCAN_CHK;
                end
            end
            S_SCAN_CHK:
            begin
                if (rdata_reg[15:0] == ERASED || next_pos > RW_S)
                begin
                    state_next = S_SCAN_END;
                end
                else
                begin
                    if (load_reg && rdata_reg[15:0] == ltag_reg)
                    begin
                        hit_next    = 1'b1;
                        hitpos_next = pos_reg;
                    end
                    if (!load_reg && rdata_reg[15:0] != stag_reg)
                    begin
                        kept_next = kept_reg + rec_sz;
                    end
                    pos_next   = next_pos;
                    state_next = S_SCAN_RD;
                end
            end
            S_SCAN_END:
            begin
                if (load_reg)
                begin
                    if (hit_reg)
                    begin
                        state_next = S_LHDR;
                    end
                    else
                    begin
                        res_next   = '{ST_NOT_FOUND, 32'h0, 3'd0, 1'b1};
                        state_next = S_EMIT;
                    end
                end
                else
                begin
                    end_next   = pos_reg;
                    state_next = S_FIT;
                end
            end
            S_FIT:
            begin
                if (SW'(2) + kept_reg + rec_words({8'h0, slen_reg}) > RW_S)
                begin
                    verdict_next = ST_NO_ROOM[1:0];
                    state_next   = S_WORD;
                end
                else
                begin
                    src_next   = SW'(2);
                    dst_next   = SW'(2);
                    pos_next   = SW'(2);
                    state_next = valid_reg ? S_CMP_RD : S_FILL;
                end
            end
            S_CMP_RD:
            begin
                if (src_reg >= end_reg)
                begin
                    pos_next   = dst_reg;
                    state_next = S_FILL;
                end
                else
                begin
                    re         = 1'b1;
                    raddr      = src_reg[AW-1:0];
                    state_next = S_CMP_CHK;
                end
            end
            S_CMP_CHK:
            begin
                sz_next = rec_sz;
                if (rdata_reg[15:0] != stag_reg)
                begin
                    cnt_next   = '0;
                    state_next = S_CP_RD;
                end
                else
                begin
                    src_next   = src_reg + rec_sz;
                    state_next = S_CMP_RD;
                end
            end
            S_CP_RD:
            begin
                re         = 1'b1;
                raddr      = AW'(src_reg + cnt_reg);
                state_next = S_CP_WR;
            end
            S_CP_WR:
            begin
                we       = 1'b1;
                waddr    = AW'(dst_reg + cnt_reg);
                wdata    = rdata_reg;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg + 1'b1 == sz_reg)
                begin
                    src_next   = src_reg + sz_reg;
                    dst_next   = dst_reg + sz_reg;
                    state_next = S_CMP_RD;
                end
                else
                begin
                    state_next = S_CP_RD;
                end
            end
            S_FILL:
            begin
                if (pos_reg < RW_S)
                begin
                    we       = 1'b1;
                    waddr    = pos_reg[AW-1:0];
                    wdata    = '1;
                    pos_next = pos_reg + 1'b1;
                end
                else
                begin
                    state_next = S_HDRW0;
                end
            end
            S_HDRW0:
            begin
                we         = 1'b1;
                waddr      = AW'(0);
                wdata      = MAGIC;
                state_next = S_HDRW1;
            end
            S_HDRW1:
            begin
                we           = 1'b1;
                waddr        = AW'(1);
                wdata        = VERSION;
                wpos_next    = dst_reg;
                verdict_next = ST_OK[1:0];
                state_next   = S_WORD;
            end
            S_WORD:
            begin
                if (verdict_reg != ST_OK[1:0] || taken_reg >= slen_reg)
                begin
                    state_next = S_WEND;
                end
                else
                begin
                    bcnt_next  = '0;
                    wbase_next = taken_reg;
                    wacc_next  = '1;
                    state_next = S_BYTE;
                end
            end
            S_BYTE:
            begin
                if (bcnt_reg < 3'd4 && taken_reg < slen_reg)
                begin
                    crc_next = crc_byte(crc_reg, cur_byte);
                    wacc_next[{bcnt_reg[1:0], 3'b000} +: 8] = cur_byte;
                    taken_next = taken_reg + 1'b1;
                    bcnt_next  = bcnt_reg + 1'b1;
                end
                else
                begin
                    we         = 1'b1;
                    waddr      = AW'(wpos_reg + SW'(2) + SW'(wbase_reg[7:2]));
                    wdata      = wacc_reg;
                    state_next = S_WEND;
                end
            end
            S_WEND:
            begin
                if (!last_reg)
                begin
                    state_next = S_IDLE;
                end
                else if (verdict_reg == ST_OK[1:0] && taken_reg < slen_reg)
                begin
                    // Bytes missing from a short save are taken as zero.
                    data_next  = '0;
                    state_next = S_WORD;
                end
                else if (verdict_reg == ST_OK[1:0])
                begin
                    we         = 1'b1;
                    waddr      = AW'(wpos_reg + SW'(1));
                    wdata      = ~crc_reg;
                    state_next = S_TAGW;
                end
                else
                begin
                    res_next   = '{{1'b0, verdict_reg}, 32'h0, 3'd0, 1'b1};
                    state_next = S_EMIT;
                end
            end
            S_TAGW:
            begin
                // The tag word goes last so the record joins the chain whole.
                we         = 1'b1;
                waddr      = wpos_reg[AW-1:0];
                wdata      = {8'h0, slen_reg, stag_reg};
                res_next   = '{ST_OK, 32'h0, 3'd0, 1'b1};
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (!res_full)
                begin
                    res_push   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_LHDR:
            begin
                re         = 1'b1;
                raddr      = hitpos_reg[AW-1:0];
                state_next = S_LCHK;
            end
            S_LCHK:
            begin
                if (rdata_reg[31:16] != {8'h0, llen_reg} || rdata_reg[31:16] > MAX_L)
                begin
                    res_next   = '{ST_LENGTH, 32'h0, 3'd0, 1'b1};
                    state_next = S_EMIT;
                end
                else
                begin
                    re         = 1'b1;
                    raddr      = AW'(hitpos_reg + SW'(1));
                    state_next = S_LCRCW;
                end
            end
            S_LCRCW:
            begin
                crcst_next = rdata_reg;
                lcrc_next  = CRC_INIT;
                idx_next   = '0;
                state_next = S_LC_RD;
            end
            S_LC_RD:
            begin
                if (idx_reg >= {1'b0, llen_reg})
                begin
                    state_next = S_LC_CMP;
                end
                else
                begin
                    re         = 1'b1;
                    raddr      = AW'(hitpos_reg + SW'(2) + SW'(idx_reg[8:2]));
                    bcnt_next  = '0;
                    state_next = S_LC_BYTES;
                end
            end
            S_LC_BYTES:
            begin
                if (bcnt_reg < 3'd4 && idx_reg < {1'b0, llen_reg})
                begin
                    lcrc_next = crc_byte(lcrc_reg, rd_byte);
                    idx_next  = idx_reg + 1'b1;
                    bcnt_next = bcnt_reg + 1'b1;
                end
                else
                begin
                    state_next = S_LC_RD;
                end
            end
            S_LC_CMP:
            begin
                if (~lcrc_reg != crcst_reg)
                begin
                    res_next   = '{ST_CRC, 32'h0, 3'd0, 1'b1};
                    state_next = S_EMIT;
                end
                else if (llen_reg == 8'd0)
                begin
                    res_next   = '{ST_OK, 32'h0, 3'd0, 1'b1};
                    state_next = S_EMIT;
                end
                else
                begin
                    idx_next   = '0;
                    state_next = S_LW_RD;
                end
            end
            S_LW_RD:
            begin
                re         = 1'b1;
                raddr      = AW'(hitpos_reg + SW'(2) + SW'(idx_reg[8:2]));
                state_next = S_LW_EMIT;
            end
            S_LW_EMIT:
            begin
                res = '{ST_OK, pw, vb, (idx_reg + 9'd4 >= {1'b0, llen_reg})};
                if (!res_full)
                begin
                    res_push = 1'b1;
                    idx_next = idx_reg + 9'd4;
                    if (idx_reg + 9'd4 >= {1'b0, llen_reg})
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        state_next = S_LW_RD;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_CLR;
            pos_reg     <= '0;
            verdict_reg <= '0;
            taken_reg   <= '0;
            crc_reg     <= CRC_INIT;
            wpos_reg    <= '0;
            stag_reg    <= '0;
            slen_reg    <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            pos_reg     <= pos_next;
            verdict_reg <= verdict_next;
            taken_reg   <= taken_next;
            crc_reg     <= crc_next;
            wpos_reg    <= wpos_next;
            stag_reg    <= stag_next;
            slen_reg    <= slen_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ltag_reg   <= ltag_next;
        llen_reg   <= llen_next;
        data_reg   <= data_next;
        last_reg   <= last_next;
        load_reg   <= load_next;
        hdr_ok_reg <= hdr_ok_next;
        valid_reg  <= valid_next;
        kept_reg   <= kept_next;
        end_reg    <= end_next;
        src_reg    <= src_next;
        dst_reg    <= dst_next;
        sz_reg     <= sz_next;
        cnt_reg    <= cnt_next;
        hit_reg    <= hit_next;
        hitpos_reg <= hitpos_next;
        idx_reg    <= idx_next;
        bcnt_reg   <= bcnt_next;
        wbase_reg  <= wbase_next;
        wacc_reg   <= wacc_next;
        lcrc_reg   <= lcrc_next;
        crcst_reg  <= crcst_next;
        res_reg    <= res_next;
    end
endmodule

[hw/rtl/tagged_record_store.sv]
// Commands are taken one beat at a time by a single-port sequencer over the region memory;
// each save word is packed byte by byte and written, and the last one also pads a short
// save and, if it is accepted, writes CRC and tag word.
// Reset: control clears at once, then a clearing pass writes all REGION_BYTES/4 words of the
// region to all ones, with full held high for its length.
`include "assert_macros.svh"

module tagged_record_store #(
    parameter int REGION_BYTES     = 4096,
    parameter int MAX_RECORD_BYTES = 252
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic        action,
    input  logic [15:0] tag,
    input  logic [7:0]  length,
    input  logic [31:0] data_word,
    input  logic        last,
    output logic        empty,
    input  logic        pop,
    output logic [2:0]  status,
    output logic [31:0] payload_word,
    output logic [2:0]  valid_bytes,
    output logic        final_res
);
    import trs_pkg::*;

    cmd_t cmd_in;
    cmd_t cmd_out;
    logic cmd_push;
    logic cmd_full;
    logic cmd_pop;
    logic cmd_empty;
    res_t res_in;
    res_t res_out;
    logic res_push;
    logic res_full;
    logic clearing;

    trs_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .action    (action),
        .tag       (tag),
        .length    (length),
        .data_word (data_word),
        .last      (last),
        .hold      (clearing),
        .cmd_full  (cmd_full),
        .cmd_push  (cmd_push),
        .cmd       (cmd_in)
    );

    trs_fifo #(
        .W     ($bits(cmd_t)),
        .DEPTH (4)
    ) u_cmd_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (cmd_push),
        .wr_data (cmd_in),
        .full    (cmd_full),
        .rd_en   (cmd_pop),
        .rd_data (cmd_out),
        .empty   (cmd_empty)
    );

    trs_engine #(
        .REGION_BYTES     (REGION_BYTES),
        .MAX_RECORD_BYTES (MAX_RECORD_BYTES)
    ) u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd_out),
        .cmd_empty (cmd_empty),
        .cmd_pop   (cmd_pop),
        .res       (res_in),
        .res_push  (res_push),
        .res_full  (res_full),
        .clearing  (clearing)
    );

    trs_fifo #(
        .W     ($bits(res_t)),
        .DEPTH (4)
    ) u_res_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (res_push),
        .wr_data (res_in),
        .full    (res_full),
        .rd_en   (pop),
        .rd_data (res_out),
        .empty   (empty)
    );

    assign status       = res_out.status;
    assign payload_word = res_out.payload_word;
    assign valid_bytes  = res_out.valid_bytes;
    assign final_res    = res_out.final_res;

    `CHK_IMPLY(a_res_no_overflow, res_push, !res_full, "result beat pushed into a full queue")
    `CHK_IMPLY(a_cmd_no_underflow, cmd_pop, !cmd_empty, "command popped from an empty queue")
    `CHK_IMPLY(a_clear_blocks_input, clearing, full, "input open during the clearing pass")
    `CHK_IMPLY(a_fail_is_single, !empty && status != ST_OK,
               final_res && valid_bytes == 3'd0, "failed result is not a lone empty beat")
endmodule
